/* hw/rtl/rpc_pkg.sv */
// package of the relation property checker: transaction payload types
// and the command and status groups between controller and datapath
// depends on nothing
`default_nettype none

package rpc_pkg;

  localparam int unsigned IndexWidth = 6;
  localparam int unsigned CountWidth = 13;

  typedef struct packed {
    logic [IndexWidth-1:0] left_index;
    logic [IndexWidth-1:0] right_index;
    logic                  final_pair;
  } pair_t;

  typedef struct packed {
    logic                  reflexive;
    logic                  symmetric;
    logic                  transitive;
    logic                  equivalence;
    logic                  antisymmetric;
    logic                  partial_order;
    logic                  connex;
    logic                  linear_order;
    logic [CountWidth-1:0] distinct_pairs;
  } verdict_t;

  // controller to datapath
  typedef struct packed {
    logic accept;     // capture pair, read its row and column
    logic ins_write;  // store pair unless duplicate or out of range
    logic ev_start;   // row walk starts at row zero
    logic ev_rd_a;    // read row a and column a
    logic ev_latch;   // hold row a, fold row-level checks, column walk to zero
    logic ev_rd_b;    // read row b for the transitivity check
    logic ev_chk;     // row b must lie inside row a
    logic b_next;
    logic a_next;
    logic out_load;   // load result, clear the store
  } rpc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic final_q;
    logic a_last;
    logic b_last;
    logic b_hit;
    logic out_free;
  } rpc_status_t;

endpackage

`default_nettype wire

/* hw/rtl/rpc_datapath.sv */
// datapath of the relation property checker: row and column bit memories,
// domain and range masks, pair count, property flags and result register
// depends on rpc_pkg
`default_nettype none

module rpc_datapath import rpc_pkg::*; #(
  parameter int unsigned Elements = 64,
  parameter int unsigned Aw = (Elements > 1) ? $clog2(Elements) : 1
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire pair_t       in_data_i,
  input  wire rpc_cmd_t    cmd_i,
  output      rpc_status_t status_o,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      verdict_t    out_data_o
);

  localparam logic [CountWidth-1:0] CountMax = '1;

  logic [Elements-1:0] row_mem [Elements];
  logic [Elements-1:0] col_mem [Elements];
  logic [Elements-1:0] row_vld_q, col_vld_q;

  logic [Elements-1:0] rda_q, rdc_q, rdb_q;
  logic                rda_vld_q, rdc_vld_q, rdb_vld_q;
  logic [Elements-1:0] rowa_eff, cola_eff, rowb_eff;

  logic [Aw-1:0] x_q, y_q, a_q, b_q;
  logic          inr_q, fin_q;
  logic [Aw-1:0] addr_a, addr_c;
  logic          in_range;

  logic [Elements-1:0] dom_q, rng_q, rowa_q, appear;
  logic [Elements-1:0] xbit, ybit, abit;
  logic [CountWidth-1:0] cnt_q;
  logic refl_q, symm_q, trans_q, anti_q, conn_q;
  logic dup, wr;
  logic out_valid_q;
  verdict_t out_q;

  assign in_range = (32'(in_data_i.left_index) < Elements) &&
                    (32'(in_data_i.right_index) < Elements);
  assign addr_a = cmd_i.accept ? Aw'(in_data_i.left_index) : a_q;
  assign addr_c = cmd_i.accept ? Aw'(in_data_i.right_index) : a_q;

  assign rowa_eff = rda_vld_q ? rda_q : '0;
  assign cola_eff = rdc_vld_q ? rdc_q : '0;
  assign rowb_eff = rdb_vld_q ? rdb_q : '0;

  assign xbit = {{(Elements-1){1'b0}}, 1'b1} << x_q;
  assign ybit = {{(Elements-1){1'b0}}, 1'b1} << y_q;
  assign abit = {{(Elements-1){1'b0}}, 1'b1} << a_q;
  assign appear = dom_q | rng_q;

  assign dup = rowa_eff[y_q];
  assign wr  = cmd_i.ins_write && inr_q && !dup;

  // memories: one write port, registered reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept || cmd_i.ev_rd_a) begin
      rda_q <= row_mem[addr_a];
      rdc_q <= col_mem[addr_c];
    end
    if (cmd_i.ev_rd_b) begin
      rdb_q <= row_mem[b_q];
    end
    if (wr) begin
      row_mem[x_q] <= rowa_eff | ybit;
      col_mem[y_q] <= cola_eff | xbit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q   <= '0;
      col_vld_q   <= '0;
      rda_vld_q   <= 1'b0;
      rdc_vld_q   <= 1'b0;
      rdb_vld_q   <= 1'b0;
      x_q         <= '0;
      y_q         <= '0;
      inr_q       <= 1'b0;
      fin_q       <= 1'b0;
      a_q         <= '0;
      b_q         <= '0;
      dom_q       <= '0;
      rng_q       <= '0;
      rowa_q      <= '0;
      cnt_q       <= '0;
      refl_q      <= 1'b1;
      symm_q      <= 1'b1;
      trans_q     <= 1'b1;
      anti_q      <= 1'b1;
      conn_q      <= 1'b1;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cmd_i.accept || cmd_i.ev_rd_a) begin
        rda_vld_q <= row_vld_q[addr_a];
        rdc_vld_q <= col_vld_q[addr_c];
      end
      if (cmd_i.ev_rd_b) begin
        rdb_vld_q <= row_vld_q[b_q];
      end
      if (cmd_i.accept) begin
        x_q   <= Aw'(in_data_i.left_index);
        y_q   <= Aw'(in_data_i.right_index);
        inr_q <= in_range;
        fin_q <= in_data_i.final_pair;
      end
      if (wr) begin
        row_vld_q[x_q] <= 1'b1;
        col_vld_q[y_q] <= 1'b1;
        dom_q          <= dom_q | xbit;
        rng_q          <= rng_q | ybit;
        if (cnt_q != CountMax) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (cmd_i.ev_start) begin
        a_q <= '0;
      end else if (cmd_i.a_next) begin
        a_q <= a_q + 1'b1;
      end
      if (cmd_i.ev_latch) begin
        b_q    <= '0;
        rowa_q <= rowa_eff;
        if (dom_q[a_q] && !rowa_eff[a_q]) refl_q <= 1'b0;
        if (|(rowa_eff & ~cola_eff)) symm_q <= 1'b0;
        if (|(rowa_eff & cola_eff & ~abit)) anti_q <= 1'b0;
        if (appear[a_q] && |(appear & ~rowa_eff & ~cola_eff)) conn_q <= 1'b0;
      end else if (cmd_i.b_next) begin
        b_q <= b_q + 1'b1;
      end
      if (cmd_i.ev_chk && |(rowb_eff & ~rowa_q)) begin
        trans_q <= 1'b0;
      end
      if (cmd_i.out_load) begin
        out_valid_q          <= 1'b1;
        out_q.reflexive      <= refl_q;
        out_q.symmetric      <= symm_q;
        out_q.transitive     <= trans_q;
        out_q.equivalence    <= refl_q & symm_q & trans_q;
        out_q.antisymmetric  <= anti_q;
        out_q.partial_order  <= refl_q & anti_q & trans_q;
        out_q.connex         <= conn_q;
        out_q.linear_order   <= refl_q & anti_q & trans_q & conn_q;
        out_q.distinct_pairs <= cnt_q;
        row_vld_q <= '0;
        col_vld_q <= '0;
        dom_q     <= '0;
        rng_q     <= '0;
        cnt_q     <= '0;
        refl_q    <= 1'b1;
        symm_q    <= 1'b1;
        trans_q   <= 1'b1;
        anti_q    <= 1'b1;
        conn_q    <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.final_q  = fin_q;
  assign status_o.a_last   = (a_q == Aw'(Elements - 1));
  assign status_o.b_last   = (b_q == Aw'(Elements - 1));
  assign status_o.b_hit    = rowa_q[b_q];
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* hw/rtl/rpc_ctrl.sv */
// controller of the relation property checker: pair insert sequence
// and the row and column walk of the evaluation
// depends on rpc_pkg
`default_nettype none

module rpc_ctrl import rpc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire rpc_status_t status_i,
  output      rpc_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    IDLE, INSERT, EV_READ, EV_LATCH, EV_SCAN, EV_CHECK, EV_OUT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = INSERT;
        end
      end
      INSERT: begin
        cmd_o.ins_write = 1'b1;
        if (status_i.final_q) begin
          cmd_o.ev_start = 1'b1;
          state_d        = EV_READ;
        end else begin
          state_d = IDLE;
        end
      end
      EV_READ: begin
        cmd_o.ev_rd_a = 1'b1;
        state_d       = EV_LATCH;
      end
      EV_LATCH: begin
        cmd_o.ev_latch = 1'b1;
        state_d        = EV_SCAN;
      end
      EV_SCAN, EV_CHECK: begin
        cmd_o.ev_chk = (state_q == EV_CHECK);
        if (state_q == EV_SCAN && status_i.b_hit) begin
          cmd_o.ev_rd_b = 1'b1;
          state_d       = EV_CHECK;
        end else if (!status_i.b_last) begin
          cmd_o.b_next = 1'b1;
          state_d      = EV_SCAN;
        end else if (status_i.a_last) begin
          state_d = EV_OUT;
        end else begin
          cmd_o.a_next = 1'b1;
          state_d      = EV_READ;
        end
      end
      EV_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = IDLE;
        end
      end
      default: state_d = IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != IDLE);

endmodule

`default_nettype wire

/* hw/rtl/relation_property_checker_core.sv */
// top level of the relation property checker
// depends on rpc_pkg, rpc_ctrl and rpc_datapath
//
// each input transaction carries one ordered pair of element indices; the
// pair is set in an adjacency bit matrix kept as a row memory and a
// transposed column memory, and a pair already present is ignored, as is a
// pair with an index of Elements or more. a plain pair takes a memory
// read, then a write. the pair marked final is stored, then the relation
// is evaluated by walking the rows: per row a read step and a latch step,
// then a scan step for each column, plus a check step for each set bit of
// that row for the transitivity check, which reads the row named by that
// bit through the second read port of the row memory. this walk sets the
// evaluation time. one result transaction then leaves through an output
// register, which may still hold the previous result while new pairs
// load; the store is cleared together with the result load by dropping
// per-row valid bits. an empty relation gives all flags set and a count
// of zero; the count saturates at its 13-bit maximum.
`default_nettype none

module relation_property_checker_core import rpc_pkg::*; #(
  parameter int unsigned Elements = 64
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output      logic     in_stall_o,
  input  wire pair_t    in_data_i,
  output      logic     out_valid_o,
  input  wire logic     out_stall_i,
  output      verdict_t out_data_o
);

  rpc_cmd_t    cmd;
  rpc_status_t status;

  // sequencer for insert and evaluation walk
  rpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // matrix storage, property flags and result register
  rpc_datapath #(
    .Elements (Elements)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

/* sim/relation_property_checker_core_tb.sv */
// testbench of relation_property_checker_core: random and directed pair
// transactions, a built-in relation predictor and a field-wise verdict check
// depends on rpc_pkg and relation_property_checker_core
`default_nettype none

module relation_property_checker_core_tb;
  import rpc_pkg::*;

  localparam int unsigned Elements = 64;
  localparam int unsigned CountSat = 8191;
  // a full evaluation walk plus margin, used for the settle time at the end
  localparam int unsigned EvalCycles = Elements * (Elements + 2) + 4096 + 64;
  localparam longint unsigned CycleLimit = 64'd40_000_000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  pair_t    in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  verdict_t out_data;

  relation_property_checker_core #(.Elements(Elements)) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always #5 clk = ~clk;

  // pairs waiting to be driven, verdicts waiting to arrive
  pair_t    pair_queue[$];
  verdict_t verdict_queue[$];
  int unsigned mismatch_count = 0;
  longint unsigned cycle_count = 0;
  bit no_idle = 1'b0;          // stretch with no idling on either side
  bit hold_sender = 1'b0;      // sender pauses while this is set

  // predictor state: relation bits plus which elements appear
  logic [Elements-1:0] rel_rows[Elements];
  logic [Elements-1:0] dom_set, rng_set;
  int unsigned         stored_pairs;

  function automatic void clear_relation();
    for (int i = 0; i < Elements; i++) rel_rows[i] = '0;
    dom_set = '0;
    rng_set = '0;
    stored_pairs = 0;
  endfunction

  // folds one pair into the relation; on a final pair, returns the verdict
  function automatic bit predict_verdict(input pair_t p, output verdict_t v);
    bit refl, symm, trans, anti, conn;
    logic [Elements-1:0] seen;
    int unsigned l, r;
    l = 32'(p.left_index);
    r = 32'(p.right_index);
    v = '0;
    if (l < Elements && r < Elements && !rel_rows[l][r]) begin
      rel_rows[l][r] = 1'b1;
      dom_set[l] = 1'b1;
      rng_set[r] = 1'b1;
      stored_pairs++;
    end
    if (!p.final_pair) return 1'b0;
    refl = 1; symm = 1; trans = 1; anti = 1; conn = 1;
    seen = dom_set | rng_set;
    for (int a = 0; a < Elements; a++) begin
      if (dom_set[a] && !rel_rows[a][a]) refl = 0;
      for (int b = 0; b < Elements; b++) begin
        if (rel_rows[a][b] && !rel_rows[b][a]) symm = 0;
        if (rel_rows[a][b] && rel_rows[b][a] && a != b) anti = 0;
        if (seen[a] && seen[b] && !rel_rows[a][b] && !rel_rows[b][a]) conn = 0;
        // row b must be a subset of row a wherever a relates to b
        if (rel_rows[a][b] && ((rel_rows[b] & ~rel_rows[a]) != '0)) trans = 0;
      end
    end
    v.reflexive      = refl;
    v.symmetric      = symm;
    v.transitive     = trans;
    v.equivalence    = refl && symm && trans;
    v.antisymmetric  = anti;
    v.partial_order  = refl && anti && trans;
    v.connex         = conn;
    v.linear_order   = refl && anti && trans && conn;
    v.distinct_pairs = 13'((stored_pairs > CountSat) ? CountSat : stored_pairs);
    clear_relation();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d",
             cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // reset once, then count cycles and stop on the limit
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  // driver: a transaction holds until accepted, then the next one or an idle
  always @(posedge clk) begin
    verdict_t v;
    if (rst_n) begin
      if (!in_valid || !in_stall) begin
        if (pair_queue.size() != 0 && !hold_sender &&
            (no_idle || $urandom_range(99) >= 21)) begin
          in_data <= pair_queue[0];
          in_valid <= 1'b1;
          if (predict_verdict(pair_queue[0], v)) verdict_queue = {verdict_queue, v};
          void'(pair_queue.pop_front());
        end else begin
          in_valid <= 1'b0;
          // idle payload stays random so stray values never matter
          in_data <= pair_t'(13'($urandom));
        end
      end
    end
  end

  // monitor: compare each accepted verdict with the oldest prediction
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (verdict_queue.size() == 0) begin
          report_mismatch("unexpected verdict", 1, 0);
        end else begin
          want = verdict_queue.pop_front();
          if (out_data.reflexive != want.reflexive)
            report_mismatch("reflexive", out_data.reflexive, want.reflexive);
          if (out_data.symmetric != want.symmetric)
            report_mismatch("symmetric", out_data.symmetric, want.symmetric);
          if (out_data.transitive != want.transitive)
            report_mismatch("transitive", out_data.transitive, want.transitive);
          if (out_data.equivalence != want.equivalence)
            report_mismatch("equivalence", out_data.equivalence, want.equivalence);
          if (out_data.antisymmetric != want.antisymmetric)
            report_mismatch("antisymmetric", out_data.antisymmetric,
                            want.antisymmetric);
          if (out_data.partial_order != want.partial_order)
            report_mismatch("partial_order", out_data.partial_order,
                            want.partial_order);
          if (out_data.connex != want.connex)
            report_mismatch("connex", out_data.connex, want.connex);
          if (out_data.linear_order != want.linear_order)
            report_mismatch("linear_order", out_data.linear_order,
                            want.linear_order);
          if (out_data.distinct_pairs != want.distinct_pairs)
            report_mismatch("distinct_pairs", out_data.distinct_pairs,
                            want.distinct_pairs);
        end
      end
      out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 21);
    end
  end

  function automatic pair_t mk(input int l, input int r, input bit f);
    pair_t p;
    p.left_index = 6'(l);
    p.right_index = 6'(r);
    p.final_pair = f;
    return p;
  endfunction

  function automatic void queue_pair(input pair_t p);
    pair_queue = {pair_queue, p};
  endfunction

  // queues one relation of n pairs, plus reverse pairs for shape 3, drawn from a set of k elements
  task automatic add_relation(input int n, input int base, input int k,
                              input int shape);
    int l, r;
    for (int i = 0; i < n; i++) begin
      l = base + $urandom_range(k - 1);
      r = base + $urandom_range(k - 1);
      case (shape)
        1: r = l;                             // reflexive leaning
        2: if (l > r) begin int t = l; l = r; r = t; end  // ordered leaning
        default: ;
      endcase
      queue_pair(mk(l % Elements, r % Elements, i == n - 1));
      // symmetric leaning relations add the reverse pair too
      if (shape == 3 && i != n - 1)
        queue_pair(mk(r % Elements, l % Elements, 1'b0));
    end
  endtask

  task automatic wait_drained();
    while (pair_queue.size() != 0 || in_valid || verdict_queue.size() != 0)
      @(posedge clk);
  endtask

  int total_items;

  initial begin
    clear_relation();
    @(posedge rst_n);
    // empty-like relation: single self pair, then extremes of the indices
    queue_pair(mk(0, 0, 1));
    queue_pair(mk(63, 63, 1));
    queue_pair(mk(0, 63, 0));
    queue_pair(mk(0, 63, 0));   // duplicate ignored
    queue_pair(mk(63, 0, 1));   // symmetric, not reflexive
    // equivalence on {1,2}
    queue_pair(mk(1, 1, 0));
    queue_pair(mk(2, 2, 0));
    queue_pair(mk(1, 2, 0));
    queue_pair(mk(2, 1, 1));
    // total order on {5,6,7}
    queue_pair(mk(5, 5, 0));
    queue_pair(mk(6, 6, 0));
    queue_pair(mk(7, 7, 0));
    queue_pair(mk(5, 6, 0));
    queue_pair(mk(6, 7, 0));
    queue_pair(mk(5, 7, 1));
    // not transitive: missing 10->12
    queue_pair(mk(10, 11, 0));
    queue_pair(mk(11, 12, 1));
    // bit patterns 21 and 42 cover every index bit at both values
    queue_pair(mk(21, 42, 0));
    queue_pair(mk(42, 21, 1));
    total_items = pair_queue.size();

    // pressure: sender waits until every verdict has come
    wait_drained();
    hold_sender = 1'b1;
    add_relation(6, 0, 8, 0);
    repeat (20) @(posedge clk);
    hold_sender = 1'b0;
    total_items += 6;

    // random relations, mostly over small element sets so properties hold
    while (total_items < 1050) begin
      int n, k, shape, queued;
      n = $urandom_range(1, 12);
      k = $urandom_range(1, 6);
      shape = $urandom_range(4);
      if ($urandom_range(19) == 0) begin n = $urandom_range(20, 60); k = 64; end
      no_idle = (total_items > 500 && total_items < 650);
      queued = pair_queue.size();
      add_relation(n, $urandom_range(63), k, shape);
      total_items += pair_queue.size() - queued;
      while (pair_queue.size() > 40) @(posedge clk);
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (EvalCycles) @(posedge clk);
    if (mismatch_count == 0 && verdict_queue.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
